// ===== rtl/core/nlbt_pkg.sv =====
// nlbt_pkg: types, constants and helper functions for the notification light timer
// used by nlbt_step and notification_led_blink_timer; no dependencies

package nlbt_pkg;

    localparam int unsigned STATIC_LIMIT_S    = 3600;
    localparam int unsigned BLINK_LIMIT_S     = 3600;
    localparam int unsigned INTERVAL_LIMIT_MS = 5000;
    localparam int unsigned MS_PER_S          = 1000;

    localparam int unsigned SEC_W  = 12;
    localparam int unsigned MS_W   = 13;
    localparam int unsigned LEFT_W = 22;
    localparam int unsigned CFG_W  = 13;
    localparam int unsigned IDX_W  = 3;

    typedef enum logic [2:0] {
        ACT_TICK       = 3'd0,
        ACT_NOTIFY_ON  = 3'd1,
        ACT_NOTIFY_OFF = 3'd2,
        ACT_SUSPEND    = 3'd3,
        ACT_RESUME     = 3'd4,
        ACT_PHASE_WR   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        CMD_LEAVE = 2'd0,
        CMD_ON    = 2'd1,
        CMD_OFF   = 2'd2
    } t_cmd;

    typedef enum logic [IDX_W-1:0] {
        REG_FEATURE_EN    = 3'd0,
        REG_STATIC_EN     = 3'd1,
        REG_STATIC_SEC    = 3'd2,
        REG_BLINK_EN      = 3'd3,
        REG_BLINK_ON_MS   = 3'd4,
        REG_BLINK_OFF_MS  = 3'd5,
        REG_BLINK_SEC     = 3'd6,
        REG_STATIC_AFTER  = 3'd7
    } t_reg_idx;

    localparam logic [SEC_W-1:0] STATIC_SEC_RST = SEC_W'(60);
    localparam logic [SEC_W-1:0] BLINK_SEC_RST  = SEC_W'(60);
    localparam logic [MS_W-1:0]  BLINK_MS_RST   = MS_W'(500);

    typedef struct packed {
        logic             feature_enable;
        logic             static_enable;
        logic [SEC_W-1:0] static_seconds;
        logic             blink_enable;
        logic [MS_W-1:0]  blink_on_ms;
        logic [MS_W-1:0]  blink_off_ms;
        logic [SEC_W-1:0] blink_seconds;
        logic             static_after_blink;
    } t_cfg;

    typedef struct packed {
        logic              ongoing;
        logic              phase_on_next;
        logic              suspended;
        logic              awake_held;
        logic              blink_running;
        logic              static_running;
        logic [MS_W-1:0]   interval_left;
        logic [LEFT_W-1:0] blink_left;
        logic [LEFT_W-1:0] static_left;
    } t_state;

    function automatic logic [LEFT_W-1:0] secs_to_ms(
        input logic [SEC_W-1:0] secs,
        input logic [SEC_W-1:0] limit
    );
        logic [SEC_W-1:0] c;
        c = (secs > limit) ? limit : secs;
        return LEFT_W'(c) * LEFT_W'(MS_PER_S);
    endfunction

    function automatic logic [MS_W-1:0] interval_of(input logic [MS_W-1:0] ms);
        logic [MS_W-1:0] v;
        v = (ms > MS_W'(INTERVAL_LIMIT_MS)) ? MS_W'(INTERVAL_LIMIT_MS) : ms;
        return (v == '0) ? MS_W'(1) : v;
    endfunction

endpackage

// ===== rtl/core/nlbt_step.sv =====
// nlbt_step: next state and light command for one item
// depends on nlbt_pkg

module nlbt_step (
    input  nlbt_pkg::t_cfg    i_cfg,
    input  nlbt_pkg::t_state  i_state,
    input  nlbt_pkg::t_action i_action,
    input  logic              i_phase_value,
    output nlbt_pkg::t_state  o_state,
    output nlbt_pkg::t_cmd    o_cmd
);
    import nlbt_pkg::*;

    t_state s;
    t_cmd   cmd;
    logic   stop;

    always_comb begin
        s    = i_state;
        cmd  = CMD_LEAVE;
        stop = 1'b0;
        unique case (i_action)
            ACT_TICK: begin
                if (s.static_running) begin
                    if (s.static_left != '0) begin
                        s.static_left = s.static_left - LEFT_W'(1);
                    end
                    if (s.static_left == '0) begin
                        stop = 1'b1;
                    end
                end
                if (!stop && s.blink_running) begin
                    if (s.blink_left != '0) begin
                        s.blink_left = s.blink_left - LEFT_W'(1);
                    end
                    if (s.interval_left != '0) begin
                        s.interval_left = s.interval_left - MS_W'(1);
                    end
                    if (s.interval_left == '0) begin
                        if (s.ongoing && s.blink_left != '0) begin
                            if (s.phase_on_next) begin
                                s.interval_left = interval_of(i_cfg.blink_on_ms);
                                s.phase_on_next = 1'b0;
                                cmd             = CMD_ON;
                            end else begin
                                s.interval_left = interval_of(i_cfg.blink_off_ms);
                                s.phase_on_next = 1'b1;
                                cmd             = CMD_OFF;
                            end
                        end else if (s.ongoing && i_cfg.static_after_blink
                                     && i_cfg.static_seconds != '0) begin
                            s.blink_running  = 1'b0;
                            s.interval_left  = '0;
                            s.blink_left     = '0;
                            s.phase_on_next  = 1'b0;
                            s.static_left    = secs_to_ms(i_cfg.static_seconds,
                                                          SEC_W'(STATIC_LIMIT_S));
                            s.static_running = 1'b1;
                            cmd              = CMD_ON;
                        end else begin
                            stop = 1'b1;
                        end
                    end
                end
            end
            ACT_NOTIFY_ON: begin
                if (i_cfg.feature_enable) begin
                    s.awake_held = 1'b1;
                    if (i_cfg.blink_enable && i_cfg.blink_seconds != '0) begin
                        s.blink_left    = secs_to_ms(i_cfg.blink_seconds,
                                                     SEC_W'(BLINK_LIMIT_S));
                        s.interval_left = interval_of(i_cfg.blink_on_ms);
                        s.blink_running = 1'b1;
                    end else if (i_cfg.static_enable && i_cfg.static_seconds != '0) begin
                        s.static_left    = secs_to_ms(i_cfg.static_seconds,
                                                      SEC_W'(STATIC_LIMIT_S));
                        s.static_running = 1'b1;
                    end
                    s.ongoing = 1'b1;
                    cmd       = CMD_ON;
                end
            end
            ACT_NOTIFY_OFF: begin
                stop = 1'b1;
            end
            ACT_SUSPEND: begin
                s.suspended = 1'b1;
            end
            ACT_RESUME: begin
                stop = s.ongoing;
            end
            ACT_PHASE_WR: begin
                if (s.ongoing) begin
                    s.phase_on_next = i_phase_value;
                    cmd             = i_phase_value ? CMD_OFF : CMD_ON;
                end
            end
            default: begin
            end
        endcase

        if (stop) begin
            s.phase_on_next  = 1'b0;
            s.ongoing        = 1'b0;
            s.blink_running  = 1'b0;
            s.static_running = 1'b0;
            s.interval_left  = '0;
            s.blink_left     = '0;
            s.static_left    = '0;
            s.awake_held     = 1'b0;
            cmd              = i_state.suspended ? CMD_OFF : CMD_LEAVE;
        end
        if (i_action == ACT_RESUME) begin
            s.suspended = 1'b0;
        end
    end

    assign o_state = s;
    assign o_cmd   = cmd;

endmodule

// ===== rtl/core/notification_led_blink_timer.sv =====
// notification_led_blink_timer: top level with config registers, input and result registers
// depends on nlbt_pkg and nlbt_step
//
// Each item (a one ms tick or an event) produces exactly one result item with the
// light command and the notification flags after that item. Items flow through an
// input register, one pass of combinational update logic against the state registers,
// and a result register, so one item is taken every clock cycle unless the output side
// stalls; the result is registered behind the input register. Throughput is limited by
// the single state update per cycle and by output stalls; o_in_stall rises only when both
// the input register and the result register hold items that the output side has not
// taken. Configuration writes take effect at the next edge and are meant for idle periods.

module notification_led_blink_timer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [nlbt_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [nlbt_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_action,
    input  logic                         i_phase_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [1:0]                   o_light_command,
    output logic                         o_notify_active,
    output logic                         o_next_turns_on,
    output logic                         o_wake_hold
);
    import nlbt_pkg::*;

    t_cfg     r_cfg;
    t_state   r_state;
    t_state   n_state;
    t_cmd     n_cmd;

    logic     r_in_valid;
    t_action  r_action;
    logic     r_phase;
    logic     r_out_valid;
    t_cmd     r_cmd;
    logic     r_notify_active;
    logic     r_next_turns_on;
    logic     r_wake_hold;

    logic     advance;
    logic     take_in;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign take_in    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feature_enable     <= 1'b0;
            r_cfg.static_enable      <= 1'b0;
            r_cfg.static_seconds     <= STATIC_SEC_RST;
            r_cfg.blink_enable       <= 1'b0;
            r_cfg.blink_on_ms        <= BLINK_MS_RST;
            r_cfg.blink_off_ms       <= BLINK_MS_RST;
            r_cfg.blink_seconds      <= BLINK_SEC_RST;
            r_cfg.static_after_blink <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_FEATURE_EN:   r_cfg.feature_enable     <= i_cfg_wdata[0];
                REG_STATIC_EN:    r_cfg.static_enable      <= i_cfg_wdata[0];
                REG_STATIC_SEC:   r_cfg.static_seconds     <= i_cfg_wdata[SEC_W-1:0];
                REG_BLINK_EN:     r_cfg.blink_enable       <= i_cfg_wdata[0];
                REG_BLINK_ON_MS:  r_cfg.blink_on_ms        <= i_cfg_wdata[MS_W-1:0];
                REG_BLINK_OFF_MS: r_cfg.blink_off_ms       <= i_cfg_wdata[MS_W-1:0];
                REG_BLINK_SEC:    r_cfg.blink_seconds      <= i_cfg_wdata[SEC_W-1:0];
                REG_STATIC_AFTER: r_cfg.static_after_blink <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_action <= t_action'(i_action);
            r_phase  <= i_phase_value;
        end
    end

    nlbt_step u_step (
        .i_cfg         (r_cfg),
        .i_state       (r_state),
        .i_action      (r_action),
        .i_phase_value (r_phase),
        .o_state       (n_state),
        .o_cmd         (n_cmd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_cmd           <= n_cmd;
            r_notify_active <= n_state.ongoing;
            r_next_turns_on <= n_state.phase_on_next;
            r_wake_hold     <= n_state.awake_held;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_light_command = r_cmd;
    assign o_notify_active = r_notify_active;
    assign o_next_turns_on = r_next_turns_on;
    assign o_wake_hold     = r_wake_hold;

endmodule

// ===== bench/testbench.sv =====
// testbench for notification_led_blink_timer: directed item table, then random
// sequences of ticks and events under random idling, checked against an in-bench predictor
// depends on nlbt_pkg and the notification_led_blink_timer rtl
`timescale 1ns / 1ps

module testbench;
    import nlbt_pkg::*;

    localparam logic [2:0] ACT_SPARE_6 = 3'd6;
    localparam logic [2:0] ACT_SPARE_7 = 3'd7;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STUCK_LIMIT   = 2000;
    localparam int REPORT_MAX    = 10;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} t_idle;

    typedef struct packed {
        t_cmd cmd;
        logic active;
        logic turns_on;
        logic wake;
    } t_light;

    typedef struct packed {
        bit              is_cfg;
        t_reg_idx        idx;
        logic [CFG_W-1:0] val;
        logic [2:0]      act;
        logic            pv;
        bit              typed;
        t_light          want;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [2:0]       i_action = '0;
    logic             i_phase_value = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [1:0]       o_light_command;
    logic             o_notify_active;
    logic             o_next_turns_on;
    logic             o_wake_hold;

    // predicted configuration
    logic             cfg_fe = 1'b0;
    logic             cfg_se = 1'b0;
    logic [SEC_W-1:0] cfg_ss = STATIC_SEC_RST;
    logic             cfg_be = 1'b0;
    logic [MS_W-1:0]  cfg_on_ms = BLINK_MS_RST;
    logic [MS_W-1:0]  cfg_off_ms = BLINK_MS_RST;
    logic [SEC_W-1:0] cfg_bs = BLINK_SEC_RST;
    logic             cfg_sab = 1'b0;

    // predicted light state
    logic              on_going = 1'b0;
    logic              phase_next = 1'b0;
    logic              susp = 1'b0;
    logic              awake = 1'b0;
    logic              blinking = 1'b0;
    logic              static_on = 1'b0;
    logic [MS_W-1:0]   iv_left = '0;
    logic [LEFT_W-1:0] bl_left = '0;
    logic [LEFT_W-1:0] st_left = '0;

    t_light lights_due[$];
    t_row   plan[$];
    int     errors = 0;
    int     items_sent = 0;
    int     results_seen = 0;
    int     stall_left = 0;
    int     stall_draw = 0;
    int     stuck_cycles = 0;
    t_idle  in_mode = IDLE_NONE;
    t_idle  out_mode = IDLE_NONE;
    t_light got;
    t_light want;

    notification_led_blink_timer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_phase_value  (i_phase_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_light_command(o_light_command),
        .o_notify_active(o_notify_active),
        .o_next_turns_on(o_next_turns_on),
        .o_wake_hold    (o_wake_hold)
    );

    always #1 i_clk = ~i_clk;

    function automatic int draw_wait(input t_idle mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 15);
            default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    function automatic logic [MS_W-1:0] period_ms(input logic [MS_W-1:0] ms);
        logic [MS_W-1:0] v;
        v = (ms > MS_W'(INTERVAL_LIMIT_MS)) ? MS_W'(INTERVAL_LIMIT_MS) : ms;
        if (v == '0) v = MS_W'(1);
        return v;
    endfunction

    function automatic logic [LEFT_W-1:0] secs_ms(input logic [SEC_W-1:0] s,
                                                  input int unsigned limit);
        logic [SEC_W-1:0] c;
        c = (s > SEC_W'(limit)) ? SEC_W'(limit) : s;
        return LEFT_W'(c) * LEFT_W'(MS_PER_S);
    endfunction

    function automatic t_cmd stop_light();
        on_going = 1'b0;
        phase_next = 1'b0;
        blinking = 1'b0;
        static_on = 1'b0;
        iv_left = '0;
        bl_left = '0;
        st_left = '0;
        awake = 1'b0;
        if (susp) return CMD_OFF;
        return CMD_LEAVE;
    endfunction

    function automatic t_cmd tick_ms();
        if (static_on) begin
            if (st_left != '0) st_left = st_left - 1'b1;
            if (st_left == '0) return stop_light();
        end
        if (!blinking) return CMD_LEAVE;
        if (bl_left != '0) bl_left = bl_left - 1'b1;
        if (iv_left != '0) iv_left = iv_left - 1'b1;
        if (iv_left != '0) return CMD_LEAVE;
        if (on_going && bl_left != '0) begin
            if (phase_next) begin
                iv_left = period_ms(cfg_on_ms);
                phase_next = 1'b0;
                return CMD_ON;
            end
            iv_left = period_ms(cfg_off_ms);
            phase_next = 1'b1;
            return CMD_OFF;
        end
        // blinking over: optionally fall back to a static light
        if (on_going && cfg_sab && cfg_ss != '0) begin
            blinking = 1'b0;
            iv_left = '0;
            bl_left = '0;
            phase_next = 1'b0;
            st_left = secs_ms(cfg_ss, STATIC_LIMIT_S);
            static_on = 1'b1;
            return CMD_ON;
        end
        return stop_light();
    endfunction

    function automatic t_cmd notify_on();
        if (!cfg_fe) return CMD_LEAVE;
        awake = 1'b1;
        if (cfg_be && cfg_bs != '0) begin
            bl_left = secs_ms(cfg_bs, BLINK_LIMIT_S);
            iv_left = period_ms(cfg_on_ms);
            blinking = 1'b1;
        end else if (cfg_se && cfg_ss != '0) begin
            st_left = secs_ms(cfg_ss, STATIC_LIMIT_S);
            static_on = 1'b1;
        end
        on_going = 1'b1;
        return CMD_ON;
    endfunction

    function automatic t_light predict_light(input logic [2:0] act, input logic pv);
        t_light r;
        r.cmd = CMD_LEAVE;
        case (act)
            ACT_TICK:       r.cmd = tick_ms();
            ACT_NOTIFY_ON:  r.cmd = notify_on();
            ACT_NOTIFY_OFF: r.cmd = stop_light();
            ACT_SUSPEND:    susp = 1'b1;
            ACT_RESUME: begin
                if (on_going) r.cmd = stop_light();
                susp = 1'b0;
            end
            ACT_PHASE_WR: begin
                if (on_going) begin
                    phase_next = pv;
                    r.cmd = pv ? CMD_OFF : CMD_ON;
                end
            end
            default: ;
        endcase
        r.active = on_going;
        r.turns_on = phase_next;
        r.wake = awake;
        return r;
    endfunction

    function automatic t_row cfg_row(input t_reg_idx idx, input int val);
        t_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = CFG_W'(val);
        return r;
    endfunction

    function automatic t_row item_row(input logic [2:0] act, input logic pv);
        t_row r;
        r = '0;
        r.act = act;
        r.pv = pv;
        return r;
    endfunction

    function automatic t_row check_row(input logic [2:0] act, input logic pv, input t_cmd cmd,
                                       input logic active, input logic nxt, input logic wk);
        t_row r;
        r = item_row(act, pv);
        r.typed = 1'b1;
        r.want.cmd = cmd;
        r.want.active = active;
        r.want.turns_on = nxt;
        r.want.wake = wk;
        return r;
    endfunction

    task automatic push_item(input logic [2:0] act, input logic pv, input bit typed,
                             input t_light fixed);
        int     gap;
        t_light due;
        gap = draw_wait(in_mode);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_phase_value <= pv;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        due = predict_light(act, pv);
        lights_due.push_back(typed ? fixed : due);
        items_sent++;
        if (items_sent % 64 == 0) in_mode = t_idle'($urandom_range(0, 2));
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        i_in_valid <= 1'b0;
        while (lights_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            REG_FEATURE_EN:   cfg_fe = val[0];
            REG_STATIC_EN:    cfg_se = val[0];
            REG_STATIC_SEC:   cfg_ss = val[SEC_W-1:0];
            REG_BLINK_EN:     cfg_be = val[0];
            REG_BLINK_ON_MS:  cfg_on_ms = val[MS_W-1:0];
            REG_BLINK_OFF_MS: cfg_off_ms = val[MS_W-1:0];
            REG_BLINK_SEC:    cfg_bs = val[SEC_W-1:0];
            REG_STATIC_AFTER: cfg_sab = val[0];
            default: ;
        endcase
    endtask

    task automatic set_all(input int fe, input int se, input int ss, input int be,
                           input int on_ms, input int off_ms, input int bs, input int sab);
        write_reg(REG_FEATURE_EN, CFG_W'(fe));
        write_reg(REG_STATIC_EN, CFG_W'(se));
        write_reg(REG_STATIC_SEC, CFG_W'(ss));
        write_reg(REG_BLINK_EN, CFG_W'(be));
        write_reg(REG_BLINK_ON_MS, CFG_W'(on_ms));
        write_reg(REG_BLINK_OFF_MS, CFG_W'(off_ms));
        write_reg(REG_BLINK_SEC, CFG_W'(bs));
        write_reg(REG_STATIC_AFTER, CFG_W'(sab));
    endtask

    task automatic mixed_run(input int n);
        logic [2:0] act;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < 55) act = ACT_TICK;
            else act = 3'($urandom_range(ACT_NOTIFY_ON, ACT_SPARE_7));
            push_item(act, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    // one notification left to run its timers out, with harmless noise in between
    task automatic long_run(input int n);
        logic [2:0] act;
        push_item(ACT_NOTIFY_ON, 1'($urandom_range(0, 1)), 1'b0, '0);
        for (int k = 0; k < n; k++) begin
            act = ACT_TICK;
            if ($urandom_range(0, 99) == 0) begin
                case ($urandom_range(0, 3))
                    0: act = ACT_SUSPEND;
                    1: act = ACT_PHASE_WR;
                    2: act = ACT_SPARE_6;
                    default: act = ACT_SPARE_7;
                endcase
            end
            push_item(act, 1'($urandom_range(0, 1)), 1'b0, '0);
        end
    endtask

    // result side: random stall per item, checking against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            stall_draw = draw_wait(out_mode);
            i_out_stall <= (stall_draw != 0);
            stall_left <= stall_draw;
            results_seen++;
            if (results_seen % 50 == 0) out_mode = t_idle'($urandom_range(0, 2));
            got.cmd = t_cmd'(o_light_command);
            got.active = o_notify_active;
            got.turns_on = o_next_turns_on;
            got.wake = o_wake_hold;
            if (lights_due.size() == 0) begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("result with no item pending: cmd=%0d act=%0d nxt=%0d wake=%0d",
                             got.cmd, got.active, got.turns_on, got.wake);
            end else begin
                want = lights_due.pop_front();
                if (got.cmd != want.cmd || got.active != want.active ||
                    got.turns_on != want.turns_on || got.wake != want.wake) begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display({"light mismatch at result %0d: expected cmd=%0d act=%0d ",
                                  "nxt=%0d wake=%0d, got cmd=%0d act=%0d nxt=%0d wake=%0d"},
                                 results_seen, want.cmd, want.active, want.turns_on,
                                 want.wake, got.cmd, got.active, got.turns_on, got.wake);
                end
            end
        end else if (stall_left != 0) begin
            i_out_stall <= (stall_left > 1);
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stuck_cycles <= 0;
        end else if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        // after reset, feature off: everything ignored
        plan.push_back(check_row(ACT_TICK, 1'b0, CMD_LEAVE, 1'b0, 1'b0, 1'b0));
        plan.push_back(check_row(ACT_NOTIFY_ON, 1'b1, CMD_LEAVE, 1'b0, 1'b0, 1'b0));
        plan.push_back(check_row(ACT_PHASE_WR, 1'b1, CMD_LEAVE, 1'b0, 1'b0, 1'b0));
        plan.push_back(check_row(ACT_SPARE_6, 1'b0, CMD_LEAVE, 1'b0, 1'b0, 1'b0));
        plan.push_back(check_row(ACT_SPARE_7, 1'b1, CMD_LEAVE, 1'b0, 1'b0, 1'b0));
        plan.push_back(check_row(ACT_NOTIFY_OFF, 1'b0, CMD_LEAVE, 1'b0, 1'b0, 1'b0));
        plan.push_back(check_row(ACT_SUSPEND, 1'b0, CMD_LEAVE, 1'b0, 1'b0, 1'b0));
        plan.push_back(check_row(ACT_RESUME, 1'b0, CMD_LEAVE, 1'b0, 1'b0, 1'b0));
        // feature on, no timers
        plan.push_back(cfg_row(REG_FEATURE_EN, 1));
        plan.push_back(check_row(ACT_NOTIFY_ON, 1'b0, CMD_ON, 1'b1, 1'b0, 1'b1));
        plan.push_back(check_row(ACT_TICK, 1'b0, CMD_LEAVE, 1'b1, 1'b0, 1'b1));
        plan.push_back(check_row(ACT_PHASE_WR, 1'b1, CMD_OFF, 1'b1, 1'b1, 1'b1));
        plan.push_back(check_row(ACT_PHASE_WR, 1'b0, CMD_ON, 1'b1, 1'b0, 1'b1));
        plan.push_back(check_row(ACT_SUSPEND, 1'b0, CMD_LEAVE, 1'b1, 1'b0, 1'b1));
        plan.push_back(check_row(ACT_NOTIFY_OFF, 1'b0, CMD_OFF, 1'b0, 1'b0, 1'b0));
        plan.push_back(check_row(ACT_NOTIFY_ON, 1'b0, CMD_ON, 1'b1, 1'b0, 1'b1));
        plan.push_back(check_row(ACT_RESUME, 1'b0, CMD_OFF, 1'b0, 1'b0, 1'b0));
        // zero on time acts as one ms
        plan.push_back(cfg_row(REG_BLINK_EN, 1));
        plan.push_back(cfg_row(REG_BLINK_ON_MS, 0));
        plan.push_back(cfg_row(REG_BLINK_OFF_MS, 1));
        plan.push_back(cfg_row(REG_BLINK_SEC, 1));
        plan.push_back(check_row(ACT_NOTIFY_ON, 1'b0, CMD_ON, 1'b1, 1'b0, 1'b1));
        plan.push_back(check_row(ACT_TICK, 1'b0, CMD_OFF, 1'b1, 1'b1, 1'b1));
        plan.push_back(check_row(ACT_TICK, 1'b0, CMD_ON, 1'b1, 1'b0, 1'b1));
        plan.push_back(item_row(ACT_NOTIFY_ON, 1'b0));
        plan.push_back(item_row(ACT_TICK, 1'b1));
        plan.push_back(check_row(ACT_NOTIFY_OFF, 1'b0, CMD_LEAVE, 1'b0, 1'b0, 1'b0));
        // blinking skipped, oversized static timeout and intervals
        plan.push_back(cfg_row(REG_BLINK_SEC, 0));
        plan.push_back(cfg_row(REG_STATIC_EN, 1));
        plan.push_back(cfg_row(REG_STATIC_SEC, 4095));
        plan.push_back(cfg_row(REG_STATIC_AFTER, 1));
        plan.push_back(cfg_row(REG_BLINK_ON_MS, 8191));
        plan.push_back(cfg_row(REG_BLINK_OFF_MS, 8191));
        plan.push_back(check_row(ACT_NOTIFY_ON, 1'b0, CMD_ON, 1'b1, 1'b0, 1'b1));
        plan.push_back(item_row(ACT_TICK, 1'b0));
        plan.push_back(item_row(ACT_PHASE_WR, 1'b1));
        plan.push_back(check_row(ACT_NOTIFY_OFF, 1'b0, CMD_LEAVE, 1'b0, 1'b0, 1'b0));
        // static timeout of zero is skipped
        plan.push_back(cfg_row(REG_STATIC_SEC, 0));
        plan.push_back(check_row(ACT_NOTIFY_ON, 1'b0, CMD_ON, 1'b1, 1'b0, 1'b1));
        plan.push_back(check_row(ACT_TICK, 1'b0, CMD_LEAVE, 1'b1, 1'b0, 1'b1));
        plan.push_back(check_row(ACT_NOTIFY_OFF, 1'b0, CMD_LEAVE, 1'b0, 1'b0, 1'b0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].is_cfg) write_reg(plan[k].idx, plan[k].val);
            else push_item(plan[k].act, plan[k].pv, plan[k].typed, plan[k].want);
        end

        set_all(1, $urandom_range(0, 1), $urandom_range(1, 3), $urandom_range(0, 1),
                $urandom_range(0, 20), $urandom_range(0, 20), $urandom_range(0, 2),
                $urandom_range(0, 1));
        mixed_run(300);
        // blink to its end then static light or stop, or a static light to its end
        set_all(1, 1, 1, $urandom_range(0, 1), $urandom_range(1, 9), $urandom_range(1, 9),
                1, $urandom_range(0, 1));
        long_run(1060);
        set_all(1, 1, 4095, $urandom_range(0, 1), 8191, 8191, 4095, 1);
        mixed_run(250);
        set_all(0, 1, 0, 1, 0, 0, 0, 0);
        mixed_run(100);

        i_in_valid <= 1'b0;
        while (lights_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/nlbt_pkg.sv
rtl/core/nlbt_step.sv
rtl/core/notification_led_blink_timer.sv
bench/testbench.sv
